@@ design/isl_pkg.sv @@
// Shared types and constants for the spin-flip lattice block.
`default_nettype none

package isl_pkg;

    localparam int SIDE_W   = 7;
    localparam int COORD_W  = 6;
    localparam int ENERGY_W = 5;
    localparam int TOTAL_W  = 14;
    localparam int DEFAULT_SIDE = 64;
    localparam int MIN_SIDE = 2;

    localparam int SEL_W = 3;
    localparam logic [SEL_W-1:0] NB_CENTER = 3'd0;
    localparam logic [SEL_W-1:0] NB_LEFT   = 3'd1;
    localparam logic [SEL_W-1:0] NB_RIGHT  = 3'd2;
    localparam logic [SEL_W-1:0] NB_UP     = 3'd3;
    localparam logic [SEL_W-1:0] NB_DOWN   = 3'd4;

    typedef struct packed {
        logic [COORD_W-1:0] site_row;
        logic [COORD_W-1:0] site_column;
        logic               keep_flip;
    } site_word_t;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] energy_change;
        logic signed [TOTAL_W-1:0]  total_spin;
    } result_word_t;

endpackage

`default_nettype wire

@@ design/ising_spin_flip_lattice.sv @@
// Top level of the Ising lattice spin-flip energy block.
`default_nettype none

// The lattice is held as one spin bit per site in a single RAM addressed by
// row and column. Each site word is taken in S_IDLE, then S_READ issues the
// reads of the site and its four wrapped neighbors through the one RAM read
// port, and S_LAST forms the result and, for an in-range site with keep_flip
// set, writes the flipped spin back; S_LAST waits while the output register
// holds an untaken word. Result words leave through an output register. After
// reset and after every write of side_length the RAM is swept to all spins
// up, one entry per cycle, over all 2**(2*ceil(log2(MAX_SIDE))) entries (4096
// at the default), and no site word is accepted during that sweep.
module ising_spin_flip_lattice #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write_en,
    input  wire logic [isl_pkg::SIDE_W-1:0]  cfg_write_data,
    input  wire logic                        site_valid,
    output logic                             site_ready,
    input  wire isl_pkg::site_word_t         site_word,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output isl_pkg::result_word_t            result_word
);

    import isl_pkg::*;

    localparam int RW = $clog2(MAX_SIDE);
    localparam int AW = 2 * RW;
    localparam int DEPTH = 1 << AW;
    localparam int RESET_SIDE = (MAX_SIDE < DEFAULT_SIDE) ? MAX_SIDE : DEFAULT_SIDE;
    localparam int RESET_TOTAL = RESET_SIDE * RESET_SIDE;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_LAST  = 2'd3;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [AW-1:0]            clr_addr_reg;
    logic [AW-1:0]            clr_addr_next;
    logic [SIDE_W-1:0]        side_reg;
    logic [SIDE_W-1:0]        side_next;
    logic signed [TOTAL_W-1:0] total_reg;
    logic signed [TOTAL_W-1:0] total_next;
    logic [SEL_W-1:0]         k_reg;
    logic [SEL_W-1:0]         k_next;
    logic                     s_reg;
    logic                     s_next;
    logic [2:0]               nup_reg;
    logic [2:0]               nup_next;
    site_word_t               site_reg;
    site_word_t               site_next;
    logic                     result_valid_reg;
    logic                     result_valid_next;
    result_word_t             result_reg;
    result_word_t             result_next;

    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            ctr_addr;
    logic                     in_range;
    logic                     unused_range;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic                     mem_wdata;
    logic                     mem_re;
    logic                     mem_rdata;
    logic                     finishing;
    logic [2:0]               nup_fin;
    logic signed [ENERGY_W-1:0] delta_pos;
    logic signed [ENERGY_W-1:0] delta;
    logic [SIDE_W-1:0]        cfg_side;
    logic [2*SIDE_W-1:0]      side_sq;

    isl_nbr_addr #(.MAX_SIDE(MAX_SIDE)) u_rd_addr (
        .row      (site_reg.site_row),
        .col      (site_reg.site_column),
        .side     (side_reg),
        .sel      (k_reg),
        .addr     (rd_addr),
        .in_range (unused_range)
    );

    isl_nbr_addr #(.MAX_SIDE(MAX_SIDE)) u_ctr_addr (
        .row      (site_reg.site_row),
        .col      (site_reg.site_column),
        .side     (side_reg),
        .sel      (NB_CENTER),
        .addr     (ctr_addr),
        .in_range (in_range)
    );

    isl_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_lattice (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        cfg_side = cfg_write_data;
        if (cfg_write_data < SIDE_W'(MIN_SIDE))
        begin
            cfg_side = SIDE_W'(MIN_SIDE);
        end
        if (int'(cfg_write_data) > MAX_SIDE)
        begin
            cfg_side = SIDE_W'(MAX_SIDE);
        end
        side_sq = {{SIDE_W{1'b0}}, cfg_side} * {{SIDE_W{1'b0}}, cfg_side};
    end

    always_comb
    begin
        finishing = (state_reg == S_LAST) && (!result_valid_reg || result_ready);
        nup_fin   = nup_reg + {2'b00, mem_rdata};
        delta_pos = ENERGY_W'({nup_fin, 2'b00}) - ENERGY_W'(8);
        if (!in_range)
        begin
            delta = '0;
        end
        else if (s_reg)
        begin
            delta = delta_pos;
        end
        else
        begin
            delta = -delta_pos;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        side_next         = side_reg;
        total_next        = total_reg;
        k_next            = k_reg;
        s_next            = s_reg;
        nup_next          = nup_reg;
        site_next         = site_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        mem_we            = 1'b0;
        mem_waddr         = ctr_addr;
        mem_wdata         = ~s_reg;
        mem_re            = 1'b0;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (site_valid)
                begin
                    site_next  = site_word;
                    k_next     = NB_CENTER;
                    nup_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                mem_re = 1'b1;
                if (k_reg == NB_LEFT)
                begin
                    s_next = mem_rdata;
                end
                else if (k_reg != NB_CENTER)
                begin
                    nup_next = nup_reg + {2'b00, mem_rdata};
                end
                k_next = k_reg + SEL_W'(1);
                if (k_reg == NB_DOWN)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (finishing)
                begin
                    if (in_range && site_reg.keep_flip)
                    begin
                        mem_we     = 1'b1;
                        total_next = s_reg ? total_reg - TOTAL_W'(2)
                                           : total_reg + TOTAL_W'(2);
                    end
                    result_next.energy_change = delta;
                    result_next.total_spin    = total_next;
                    result_valid_next         = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (cfg_write_en)
        begin
            side_next     = cfg_side;
            total_next    = $signed(TOTAL_W'(side_sq));
            clr_addr_next = '0;
            state_next    = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            side_reg         <= SIDE_W'(RESET_SIDE);
            total_reg        <= TOTAL_W'(RESET_TOTAL);
            result_valid_reg <= 1'b0;
            k_reg            <= NB_CENTER;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            side_reg         <= side_next;
            total_reg        <= total_next;
            result_valid_reg <= result_valid_next;
            k_reg            <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        nup_reg    <= nup_next;
        site_reg   <= site_next;
        result_reg <= result_next;
    end

    assign site_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result_word  = result_reg;

    // The spin total always has the parity of the site count.
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg[0] == side_reg[0])
        else $error("spin total parity does not match lattice size");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_LAST))
        else $error("lattice written outside clear sweep or write-back");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == S_LAST)
        else $error("result word raised without a finished site");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |=> (state_reg == S_CLEAR && clr_addr_reg == '0))
        else $error("side write did not restart the clear sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        (site_valid && site_ready) |=> (state_reg == S_READ && k_reg == NB_CENTER)
            || state_reg == S_CLEAR)
        else $error("accepted site word did not start the read sequence");

endmodule

`default_nettype wire

@@ design/isl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module isl_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/isl_nbr_addr.sv @@
// Wrapped neighbor address generation and range check for one lattice site.
`default_nettype none

module isl_nbr_addr #(
    parameter int MAX_SIDE = 64,
    localparam int RW = $clog2(MAX_SIDE)
) (
    input  wire logic [isl_pkg::COORD_W-1:0] row,
    input  wire logic [isl_pkg::COORD_W-1:0] col,
    input  wire logic [isl_pkg::SIDE_W-1:0]  side,
    input  wire logic [isl_pkg::SEL_W-1:0]   sel,
    output logic      [2*RW-1:0]             addr,
    output logic                             in_range
);

    import isl_pkg::*;

    localparam int XW = (RW > SIDE_W) ? RW : SIDE_W;

    logic [XW-1:0] side_x;
    logic [XW-1:0] last_x;
    logic [XW-1:0] row_x;
    logic [XW-1:0] col_x;
    logic [XW-1:0] left_x;
    logic [XW-1:0] right_x;
    logic [XW-1:0] up_x;
    logic [XW-1:0] down_x;
    logic [XW-1:0] r_x;
    logic [XW-1:0] c_x;

    always_comb
    begin
        side_x  = XW'(side);
        last_x  = side_x - XW'(1);
        row_x   = XW'(row);
        col_x   = XW'(col);
        left_x  = (col_x == '0) ? last_x : col_x - XW'(1);
        right_x = (col_x == last_x) ? '0 : col_x + XW'(1);
        up_x    = (row_x == '0) ? last_x : row_x - XW'(1);
        down_x  = (row_x == last_x) ? '0 : row_x + XW'(1);
        unique case (sel)
            NB_LEFT:
            begin
                r_x = row_x;
                c_x = left_x;
            end
            NB_RIGHT:
            begin
                r_x = row_x;
                c_x = right_x;
            end
            NB_UP:
            begin
                r_x = up_x;
                c_x = col_x;
            end
            NB_DOWN:
            begin
                r_x = down_x;
                c_x = col_x;
            end
            default:
            begin
                r_x = row_x;
                c_x = col_x;
            end
        endcase
        in_range = (row_x < side_x) && (col_x < side_x);
        addr     = {r_x[RW-1:0], c_x[RW-1:0]};
    end

endmodule

`default_nettype wire
